// ----- design/sactl_pkg.sv -----
// ----------------------------------------------------------------------------
// sactl_pkg
// Shared types and constants of the set-associative cache tag store: command
// codes, controller states and the per-set way lookup summary.
// ----------------------------------------------------------------------------
package sactl_pkg;

    // Width of the byte address carried by a request beat
    localparam int ADDR_W = 32;

    // Width of one true-LRU use stamp and of the global use counter
    localparam int STAMP_W = 64;

    // Way index width that covers the largest supported associativity
    localparam int MAX_WAY_W = 4;

    // Request commands; the unused code behaves as a read
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_INVAL = 2'd2
    } cmd_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Summary of one set: tag match, first free way and pseudo-LRU victim
    typedef struct packed {
        logic                 found;
        logic                 empty;
        logic [MAX_WAY_W-1:0] hit_way;
        logic [MAX_WAY_W-1:0] empty_way;
        logic [MAX_WAY_W-1:0] plru_way;
    } match_t;

endpackage

// ----- design/sactl_if.sv -----
// ----------------------------------------------------------------------------
// sactl_if
// Valid/ready channels of the cache tag store: request, response and the
// policy configuration write channel.
// ----------------------------------------------------------------------------
interface sactl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] address;

    modport source (output valid, output cmd, output address, input ready);
    modport sink   (input valid, input cmd, input address, output ready);
endinterface

interface sactl_rsp_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic       miss;
    logic       eviction;
    logic       writeback;
    logic       invalidated;
    logic [1:0] way_used;

    modport source (output valid, output hit, output miss, output eviction,
                    output writeback, output invalidated, output way_used,
                    input ready);
    modport sink   (input valid, input hit, input miss, input eviction,
                    input writeback, input invalidated, input way_used,
                    output ready);
endinterface

interface sactl_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/sactl_ram.sv -----
// ----------------------------------------------------------------------------
// sactl_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module sactl_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 1,
    parameter int DEPTH  = 2
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write one row
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read one row, hold it otherwise
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/sactl_match.sv -----
// ----------------------------------------------------------------------------
// sactl_match
// Parallel way compare of one set: first valid way with a matching tag,
// first invalid way, and the lowest way whose MRU bit is clear.
// ----------------------------------------------------------------------------
module sactl_match #(
    parameter int WAY_COUNT = 4,
    parameter int TAG_W     = 20
) (
    input  logic [WAY_COUNT-1:0][TAG_W-1:0] tag_row,
    input  logic [WAY_COUNT-1:0]            valid_row,
    input  logic [WAY_COUNT-1:0]            mru_row,
    input  logic [TAG_W-1:0]                tag,
    output sactl_pkg::match_t               result
);

    // Scan from the top way down so the lowest way wins
    always_comb
    begin
        result = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--)
        begin
            if (valid_row[w] && (tag_row[w] == tag))
            begin
                result.found   = 1'b1;
                result.hit_way = sactl_pkg::MAX_WAY_W'(w);
            end
            if (!valid_row[w])
            begin
                result.empty     = 1'b1;
                result.empty_way = sactl_pkg::MAX_WAY_W'(w);
            end
            if (!mru_row[w])
            begin
                result.plru_way = sactl_pkg::MAX_WAY_W'(w);
            end
        end
    end

endmodule

// ----- design/sactl_lru_scan.sv -----
// ----------------------------------------------------------------------------
// sactl_lru_scan
// True-LRU victim search: walks the use stamps of a set one way per cycle
// and keeps the way with the smallest stamp, the lowest way on a tie.
// ----------------------------------------------------------------------------
module sactl_lru_scan #(
    parameter int WAY_COUNT = 4,
    parameter int WAY_W     = 2
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic [WAY_COUNT-1:0][sactl_pkg::STAMP_W-1:0]  stamp_row,
    output logic                                          done,
    output logic [WAY_W-1:0]                              best_way
);

    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAY_COUNT - 1);

    logic                          busy_reg;
    logic [WAY_W-1:0]              idx_reg;
    logic [WAY_W-1:0]              best_reg;
    logic [sactl_pkg::STAMP_W-1:0] best_stamp_reg;
    logic [sactl_pkg::STAMP_W-1:0] cur_stamp;

    assign cur_stamp = stamp_row[idx_reg];
    assign done      = busy_reg && (idx_reg == LAST_WAY);
    assign best_way  = best_reg;

    // Advance the way index while busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= WAY_W'(1);
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + WAY_W'(1);
            end
        end
    end

    // Keep the smallest stamp seen so far
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            best_reg       <= '0;
            best_stamp_reg <= stamp_row[0];
        end
        else if (busy_reg && (cur_stamp < best_stamp_reg))
        begin
            best_reg       <= idx_reg;
            best_stamp_reg <= cur_stamp;
        end
    end

endmodule

// ----- design/set_assoc_cache_tag_lru.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru
// Tag store of a set-associative cache with true-LRU or pseudo-LRU
// replacement, held in a tag RAM and a line state RAM per set.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command (read, write, invalidate) and a byte address per
//   beat; rsp returns one beat per request with hit, miss, eviction,
//   writeback, invalidated and the way used. cfg writes the policy bit
//   (0 true LRU, 1 single MRU bit pseudo-LRU); write it only while idle.
//   The request beat reads the set from both RAMs; the next cycle compares
//   all ways, and once the response register is free the set is written
//   back and the response register loaded. A hit, a fill of a free way, an
//   invalidate or any pseudo-LRU miss commits from the lookup stage; a miss
//   into a full set under true LRU first walks the use stamps one way per
//   cycle. The response register frees req: the next request is taken once
//   the last one commits, while its response still waits. If rsp stalls,
//   the request waits in the lookup or done state until rsp takes the beat.
//   After reset a clearing pass zeroes all 2**floor(log2(SET_COUNT)) sets of
//   the line state RAM, one set per cycle; req.ready is low during it,
//   cfg is taken at any time.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lru #(
    parameter int SET_COUNT  = 64,
    parameter int WAY_COUNT  = 4,
    parameter int LINE_BYTES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    sactl_req_if.sink    req,
    sactl_rsp_if.source  rsp,
    sactl_cfg_if.sink    cfg
);

    localparam int STAMP_W   = sactl_pkg::STAMP_W;
    localparam int OFF_BITS  = $clog2(LINE_BYTES + 1) - 1;
    localparam int IDX_BITS  = $clog2(SET_COUNT + 1) - 1;
    localparam int LOW_BITS  = OFF_BITS + IDX_BITS;
    localparam int TAG_W     = sactl_pkg::ADDR_W - LOW_BITS;
    localparam int SET_W     = (IDX_BITS > 0) ? IDX_BITS : 1;
    localparam int SET_DEPTH = 1 << IDX_BITS;
    localparam int WAY_W     = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam int ST_W      = WAY_COUNT * (3 + STAMP_W);
    localparam int TG_W      = WAY_COUNT * TAG_W;

    localparam logic [SET_W-1:0] SET_MASK   = (IDX_BITS > 0) ? '1 : '0;
    localparam logic [SET_W-1:0] CLEAR_LAST = SET_W'(SET_DEPTH - 1);

    // Controller state
    sactl_pkg::state_t    state_reg, state_next;
    logic [SET_W-1:0]     clear_cnt_reg, clear_cnt_next;
    logic                 policy_reg, policy_next;
    logic [STAMP_W-1:0]   use_counter_reg, use_counter_next;
    logic                 out_valid_reg, out_valid_next;

    // Held request
    logic [1:0]           cmd_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [SET_W-1:0]     set_reg;

    // Response payload
    logic                 hit_reg, miss_reg, evict_reg, wb_reg, inval_reg;
    logic [1:0]           way_reg;

    // Request decode
    logic                 accept;
    logic [SET_W-1:0]     req_set;
    logic [TAG_W-1:0]     req_tag;

    // RAM rows
    logic [ST_W-1:0]                    st_rdata, st_wdata;
    logic [TG_W-1:0]                    tg_rdata;
    logic                               st_we;
    logic [SET_W-1:0]                   st_waddr;
    logic [WAY_COUNT-1:0][STAMP_W-1:0]  cur_stamp;
    logic [WAY_COUNT-1:0]               cur_mru, cur_dirty, cur_valid;
    logic [WAY_COUNT-1:0][TAG_W-1:0]    cur_tag;
    logic [WAY_COUNT-1:0][STAMP_W-1:0]  new_stamp;
    logic [WAY_COUNT-1:0]               new_mru, new_dirty, new_valid;
    logic [WAY_COUNT-1:0][TAG_W-1:0]    new_tag;

    // Lookup and decision
    sactl_pkg::match_t    match;
    logic                 scan_start, scan_done;
    logic [WAY_W-1:0]     scan_best;
    logic                 is_inval, is_write;
    logic                 need_scan, out_free, commit, touch;
    logic [WAY_W-1:0]     victim_idx, sel_idx;
    logic                 d_hit, d_miss, d_evict, d_wb, d_inval;
    logic [1:0]           d_way;

    assign accept   = req.valid && req.ready;
    assign req_set  = SET_W'(req.address >> OFF_BITS) & SET_MASK;
    assign req_tag  = TAG_W'(req.address >> LOW_BITS);
    assign req.ready = (state_reg == sactl_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;

    assign {cur_stamp, cur_mru, cur_dirty, cur_valid} = st_rdata;
    assign cur_tag  = tg_rdata;
    assign st_wdata = (state_reg == sactl_pkg::ST_CLEAR)
                      ? '0 : {new_stamp, new_mru, new_dirty, new_valid};
    assign st_we    = (state_reg == sactl_pkg::ST_CLEAR) || commit;
    assign st_waddr = (state_reg == sactl_pkg::ST_CLEAR) ? clear_cnt_reg : set_reg;

    // Line state RAM: valid, dirty, MRU bits and use stamps of a set
    sactl_ram #(
        .DATA_W (ST_W),
        .ADDR_W (SET_W),
        .DEPTH  (SET_DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (accept),
        .raddr (req_set),
        .rdata (st_rdata)
    );

    // Tag RAM: tags of a set
    sactl_ram #(
        .DATA_W (TG_W),
        .ADDR_W (SET_W),
        .DEPTH  (SET_DEPTH)
    ) u_tag_ram (
        .clk   (clk),
        .we    (commit),
        .waddr (set_reg),
        .wdata (new_tag),
        .re    (accept),
        .raddr (req_set),
        .rdata (tg_rdata)
    );

    // Compare all ways of the set
    sactl_match #(
        .WAY_COUNT (WAY_COUNT),
        .TAG_W     (TAG_W)
    ) u_match (
        .tag_row   (cur_tag),
        .valid_row (cur_valid),
        .mru_row   (cur_mru),
        .tag       (tag_reg),
        .result    (match)
    );

    // Walk the stamps for a true-LRU victim
    sactl_lru_scan #(
        .WAY_COUNT (WAY_COUNT),
        .WAY_W     (WAY_W)
    ) u_lru_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .stamp_row (cur_stamp),
        .done      (scan_done),
        .best_way  (scan_best)
    );

    // Decide the outcome and build the written-back set
    always_comb
    begin
        is_inval   = (cmd_reg == sactl_pkg::CMD_INVAL);
        is_write   = (cmd_reg == sactl_pkg::CMD_WRITE);
        need_scan  = !is_inval && !match.found && !match.empty &&
                     !policy_reg && (WAY_COUNT > 1);
        victim_idx = (policy_reg || (WAY_COUNT == 1))
                     ? WAY_W'(match.plru_way) : scan_best;
        if (match.found)
        begin
            sel_idx = WAY_W'(match.hit_way);
        end
        else if (match.empty)
        begin
            sel_idx = WAY_W'(match.empty_way);
        end
        else
        begin
            sel_idx = victim_idx;
        end

        new_stamp = cur_stamp;
        new_mru   = cur_mru;
        new_dirty = cur_dirty;
        new_valid = cur_valid;
        new_tag   = cur_tag;
        d_hit     = 1'b0;
        d_miss    = 1'b0;
        d_evict   = 1'b0;
        d_wb      = 1'b0;
        d_inval   = 1'b0;
        d_way     = 2'(sel_idx);
        touch     = !is_inval;

        if (is_inval)
        begin
            if (match.found)
            begin
                new_valid[sel_idx] = 1'b0;
                d_inval            = 1'b1;
            end
            else
            begin
                d_way = '0;
            end
        end
        else if (match.found)
        begin
            d_hit = 1'b1;
            if (is_write)
            begin
                new_dirty[sel_idx] = 1'b1;
            end
        end
        else
        begin
            d_miss             = 1'b1;
            d_evict            = !match.empty;
            d_wb               = !match.empty && cur_dirty[sel_idx];
            new_valid[sel_idx] = 1'b1;
            new_tag[sel_idx]   = tag_reg;
            new_dirty[sel_idx] = is_write;
        end

        // Refresh recency of the used way
        if (touch)
        begin
            if (!policy_reg)
            begin
                new_stamp[sel_idx] = use_counter_reg;
            end
            else
            begin
                new_mru          = '0;
                new_mru[sel_idx] = 1'b1;
            end
        end
    end

    // Next state and control
    always_comb
    begin
        state_next       = state_reg;
        clear_cnt_next   = clear_cnt_reg;
        policy_next      = policy_reg;
        use_counter_next = use_counter_reg;
        out_free         = !out_valid_reg || rsp.ready;
        commit           = 1'b0;
        scan_start       = 1'b0;

        if (cfg.valid && cfg.ready)
        begin
            policy_next = cfg.data;
        end

        unique case (state_reg)
            sactl_pkg::ST_CLEAR:
            begin
                clear_cnt_next = clear_cnt_reg + SET_W'(1);
                if (clear_cnt_reg == CLEAR_LAST)
                begin
                    state_next = sactl_pkg::ST_IDLE;
                end
            end
            sactl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sactl_pkg::ST_LOOK;
                end
            end
            sactl_pkg::ST_LOOK:
            begin
                if (need_scan)
                begin
                    scan_start = 1'b1;
                    state_next = sactl_pkg::ST_SCAN;
                end
                else if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = sactl_pkg::ST_IDLE;
                end
            end
            sactl_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = sactl_pkg::ST_DONE;
                end
            end
            sactl_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = sactl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sactl_pkg::ST_IDLE;
            end
        endcase

        if (commit && touch && !policy_reg)
        begin
            use_counter_next = use_counter_reg + STAMP_W'(1);
        end

        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sactl_pkg::ST_CLEAR;
            clear_cnt_reg   <= '0;
            policy_reg      <= 1'b0;
            use_counter_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clear_cnt_reg   <= clear_cnt_next;
            policy_reg      <= policy_next;
            use_counter_reg <= use_counter_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Hold the request beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.cmd;
            tag_reg <= req_tag;
            set_reg <= req_set;
        end
    end

    // Load the response beat
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            hit_reg   <= d_hit;
            miss_reg  <= d_miss;
            evict_reg <= d_evict;
            wb_reg    <= d_wb;
            inval_reg <= d_inval;
            way_reg   <= d_way;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.miss        = miss_reg;
    assign rsp.eviction    = evict_reg;
    assign rsp.writeback   = wb_reg;
    assign rsp.invalidated = inval_reg;
    assign rsp.way_used    = way_reg;

`ifndef SYNTH
    // An accepted request is looked up in the next cycle
    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == sactl_pkg::ST_LOOK))
        else $error("request beat not followed by lookup");

    // A committed outcome is presented on the response channel
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp.valid)
        else $error("committed outcome not presented");

    // A writeback only comes with an eviction on a miss
    a_wb_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.writeback) |-> (rsp.eviction && rsp.miss && !rsp.hit))
        else $error("writeback without eviction");

    // An invalidate outcome never reports a hit or a miss
    a_inval_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.invalidated) |-> (!rsp.hit && !rsp.miss))
        else $error("invalidate reported as hit or miss");

    // The use counter steps by one on each true-LRU touch
    a_use_step: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && touch && !policy_reg) |=>
            (use_counter_reg == STAMP_W'($past(use_counter_reg) + STAMP_W'(1))))
        else $error("use counter did not advance");
`endif

endmodule
